// ===== rtl/core/sps2p_pkg.sv =====
package sps2p_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int DATA_W = 32;
	localparam int PAIRS_W = 6;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TARGET = '0;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic final_item;
	} item_t;

	typedef struct packed {
		logic is_pair;
		logic signed [DATA_W-1:0] smaller_value;
		logic signed [DATA_W-1:0] larger_value;
		logic [PAIRS_W-1:0] pairs_found;
		logic run_end;
	} result_t;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_STORE_CLOSE,
		OP_CLOSE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

// ===== rtl/core/sps2p_ram.sv =====
module sps2p_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sps2p_front.sv =====
module sps2p_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sps2p_pkg::item_t item,
	input  logic queue_full,
	output logic push,
	output sps2p_pkg::cmd_t push_cmd
);

	logic [sps2p_pkg::CNT_W-1:0] count_q;
	logic accept;
	logic room;

	assign busy = queue_full;
	assign accept = start && !busy;
	assign room = count_q < sps2p_pkg::CNT_W'(sps2p_pkg::MAX_ITEMS);

	// drop values past capacity, but a final item still closes the run
	assign push = accept && (room || item.final_item);

	always_comb begin
		push_cmd.value = item.value;
		priority if (room && item.final_item) begin
			push_cmd.op = sps2p_pkg::OP_STORE_CLOSE;
		end else if (room) begin
			push_cmd.op = sps2p_pkg::OP_STORE;
		end else begin
			push_cmd.op = sps2p_pkg::OP_CLOSE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (item.final_item) begin
				count_q <= '0;
			end else if (room) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sps2p_queue.sv =====
module sps2p_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  sps2p_pkg::cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output sps2p_pkg::cmd_t pop_cmd
);

	sps2p_pkg::cmd_t entry_q [sps2p_pkg::QUEUE_DEPTH];
	logic [sps2p_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sps2p_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sps2p_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == sps2p_pkg::QCNT_W'(sps2p_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/sps2p_back.sv =====
module sps2p_back (
	input  logic clk,
	input  logic arst_n,
	input  logic signed [sps2p_pkg::DATA_W-1:0] target,
	input  logic cmd_valid,
	input  sps2p_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic result_strobe,
	output sps2p_pkg::result_t result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_CLOSE
	} state_t;

	state_t state_q;
	logic [sps2p_pkg::CNT_W-1:0] wcount_q;
	logic [sps2p_pkg::IDX_W-1:0] lo_q;
	logic [sps2p_pkg::IDX_W-1:0] hi_q;
	logic [sps2p_pkg::PAIRS_W-1:0] found_q;
	logic strobe_q;
	sps2p_pkg::result_t result_q;

	logic ram_we;
	logic [sps2p_pkg::DATA_W-1:0] lo_data;
	logic [sps2p_pkg::DATA_W-1:0] hi_data;
	logic [sps2p_pkg::CNT_W-1:0] run_count;
	logic signed [sps2p_pkg::DATA_W:0] sum;
	logic signed [sps2p_pkg::DATA_W:0] goal;
	logic [sps2p_pkg::IDX_W-1:0] lo_next;
	logic [sps2p_pkg::IDX_W-1:0] hi_next;

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign ram_we = cmd_pop && (cmd.op != sps2p_pkg::OP_CLOSE);
	assign run_count = (cmd.op == sps2p_pkg::OP_CLOSE) ? wcount_q : wcount_q + 1'b1;

	// two copies of the store give one read port per pointer
	sps2p_ram #(
		.WIDTH(sps2p_pkg::DATA_W),
		.DEPTH(sps2p_pkg::MAX_ITEMS)
	) u_ram_lo (
		.clk(clk),
		.we(ram_we),
		.waddr(wcount_q[sps2p_pkg::IDX_W-1:0]),
		.wdata(cmd.value),
		.raddr(lo_q),
		.rdata(lo_data)
	);

	sps2p_ram #(
		.WIDTH(sps2p_pkg::DATA_W),
		.DEPTH(sps2p_pkg::MAX_ITEMS)
	) u_ram_hi (
		.clk(clk),
		.we(ram_we),
		.waddr(wcount_q[sps2p_pkg::IDX_W-1:0]),
		.wdata(cmd.value),
		.raddr(hi_q),
		.rdata(hi_data)
	);

	assign sum = $signed({lo_data[sps2p_pkg::DATA_W-1], lo_data})
		+ $signed({hi_data[sps2p_pkg::DATA_W-1], hi_data});
	assign goal = $signed({target[sps2p_pkg::DATA_W-1], target});

	always_comb begin
		lo_next = lo_q;
		hi_next = hi_q;
		priority if (sum < goal) begin
			lo_next = lo_q + 1'b1;
		end else if (sum > goal) begin
			hi_next = hi_q - 1'b1;
		end else begin
			lo_next = lo_q + 1'b1;
			hi_next = hi_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wcount_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			found_q <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op)
							sps2p_pkg::OP_STORE: begin
								wcount_q <= wcount_q + 1'b1;
							end
							default: begin
								// close the run: walk the stored elements, if two or more
								wcount_q <= '0;
								found_q <= '0;
								lo_q <= '0;
								hi_q <= (run_count == '0) ? '0
									: sps2p_pkg::IDX_W'(run_count - 1'b1);
								state_q <= (run_count >= sps2p_pkg::CNT_W'(2)) ? S_READ
									: S_CLOSE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (sum == goal) begin
						strobe_q <= 1'b1;
						result_q.is_pair <= 1'b1;
						result_q.smaller_value <= lo_data;
						result_q.larger_value <= hi_data;
						result_q.pairs_found <= '0;
						result_q.run_end <= 1'b0;
						found_q <= found_q + 1'b1;
					end
					lo_q <= lo_next;
					hi_q <= hi_next;
					state_q <= (lo_next < hi_next) ? S_READ : S_CLOSE;
				end
				S_CLOSE: begin
					strobe_q <= 1'b1;
					result_q.is_pair <= 1'b0;
					result_q.smaller_value <= '0;
					result_q.larger_value <= '0;
					result_q.pairs_found <= found_q;
					result_q.run_end <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign result = result_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (lo_q < hi_q))
		else $error("walk step issued with crossed pointers");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_READ))
		else $error("compare without a preceding store read");

	assert property (@(posedge clk) disable iff (!arst_n)
		wcount_q <= sps2p_pkg::CNT_W'(sps2p_pkg::MAX_ITEMS))
		else $error("store fill count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |=> (result_strobe && result.run_end && !result.is_pair))
		else $error("closing transaction missing after walk");

endmodule

// ===== rtl/core/sorted_pair_sum_two_pointer.sv =====
// Sorted pair sum search, two-pointer walk.
// Input: raise start with item (value, final_item); the transaction is taken
// on a clock edge where start is high and busy is low. Values of one run are
// expected in ascending order; final_item closes the run. Up to 64 values are
// stored per run, further values are dropped (a dropped final item still
// closes the run).
// Output: one transaction per matching pair (is_pair set), then one closing
// transaction with pairs_found and run_end set. Each is shown for exactly one
// cycle under result_strobe; the receiver cannot stall it. Target sum: APB
// register at byte address 0, which the user must write only while idle;
// the block does not enforce this. Flow: loading accepts one value per
// cycle while busy is low. After the final value the walk runs S steps
// (at most N-1 for N stored values): each step reads both store copies and
// compares in the next; a pair found in a step is shown after its compare,
// and the closing transaction after the last step.
// A two-entry command queue takes the first two values of the next run while
// a walk is running; busy is then high until the walk ends.
// Reset: clears the target to 0, empties the queue and the run count; store
// contents are not cleared and are not needed.
module sorted_pair_sum_two_pointer (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sps2p_pkg::item_t item,
	output logic result_strobe,
	output sps2p_pkg::result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sps2p_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic signed [sps2p_pkg::DATA_W-1:0] target_q;
	logic [sps2p_pkg::REG_IDX_W-1:0] reg_idx;
	logic push;
	logic queue_full;
	logic queue_valid;
	logic queue_pop;
	sps2p_pkg::cmd_t push_cmd;
	sps2p_pkg::cmd_t pop_cmd;

	assign pready = 1'b1;
	assign reg_idx = paddr[sps2p_pkg::PADDR_W-1:2];
	assign prdata = (reg_idx == sps2p_pkg::REG_TARGET) ? target_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready
			&& (reg_idx == sps2p_pkg::REG_TARGET)) begin
			target_q <= pwdata;
		end
	end

	sps2p_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	sps2p_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(queue_pop),
		.valid(queue_valid),
		.pop_cmd(pop_cmd)
	);

	sps2p_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.target(target_q),
		.cmd_valid(queue_valid),
		.cmd(pop_cmd),
		.cmd_pop(queue_pop),
		.result_strobe(result_strobe),
		.result(result)
	);

endmodule
